// File: design/tss_pkg.sv
`timescale 1ns / 1ps
// Package for the trigger step sequencer: request and result payload types,
// configuration register indexes, reset values and the configuration bundle.
// No dependencies.
package tss_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PATTERN_FIRST  = 3'd0;
    localparam logic [2:0] REG_PATTERN_SECOND = 3'd1;
    localparam logic [2:0] REG_MUTE_MASK      = 3'd2;
    localparam logic [2:0] REG_STEPS          = 3'd3;
    localparam logic [2:0] REG_BARS_PER_LOOP  = 3'd4;
    localparam logic [2:0] REG_LOOPS_PER_SET  = 3'd5;
    localparam logic [2:0] REG_TRIG_LENGTH    = 3'd6;
    localparam logic [2:0] REG_BIT_ROUTE      = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Fixed constants
    localparam logic [3:0] TOP_BIT   = 4'd15;
    localparam logic [4:0] IDLE_STEP = 5'd16;

    // Register reset values
    localparam logic [4:0]  RST_STEPS     = 5'd16;
    localparam logic [7:0]  RST_BARS      = 8'd4;
    localparam logic [7:0]  RST_LOOPS     = 8'd4;
    localparam logic [7:0]  RST_TRIG_LEN  = 8'd10;
    localparam logic [23:0] RST_BIT_ROUTE = 24'd181896;

    typedef struct packed {
        logic clock_level;
        logic reset_level;
    } t_req;

    typedef struct packed {
        logic [7:0] trigger_bits;
        logic [4:0] playing_step;
        logic       bar_end;
        logic       set_end;
        logic [7:0] loop_index;
    } t_res;

    typedef struct packed {
        logic [47:0] pattern_first;
        logic [47:0] pattern_second;
        logic [5:0]  mute_mask;
        logic [4:0]  steps_in_pattern;
        logic [7:0]  bars_per_loop;
        logic [7:0]  loops_per_set;
        logic [7:0]  pulse_ticks;
        logic [23:0] bit_route;
    } t_cfg;

endpackage

// File: design/tss_req_if.sv
`timescale 1ns / 1ps
// Request channel interface: valid/ready handshake carrying one tick.
// Depends on tss_pkg.
interface tss_req_if import tss_pkg::*;;
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/tss_res_if.sv
`timescale 1ns / 1ps
// Result channel interface: valid/ready handshake carrying one tick's outputs.
// Depends on tss_pkg.
interface tss_res_if import tss_pkg::*;;
    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/tss_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register bank of the trigger step sequencer, plain write port.
// Depends on tss_pkg.
module tss_cfg_regs import tss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes, truncated to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_first    <= '0;
            r_cfg.pattern_second   <= '0;
            r_cfg.mute_mask        <= '0;
            r_cfg.steps_in_pattern <= RST_STEPS;
            r_cfg.bars_per_loop    <= RST_BARS;
            r_cfg.loops_per_set    <= RST_LOOPS;
            r_cfg.pulse_ticks      <= RST_TRIG_LEN;
            r_cfg.bit_route        <= RST_BIT_ROUTE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PATTERN_FIRST:  r_cfg.pattern_first    <= i_cfg_data;
                REG_PATTERN_SECOND: r_cfg.pattern_second   <= i_cfg_data;
                REG_MUTE_MASK:      r_cfg.mute_mask        <= i_cfg_data[5:0];
                REG_STEPS:          r_cfg.steps_in_pattern <= i_cfg_data[4:0];
                REG_BARS_PER_LOOP:  r_cfg.bars_per_loop    <= i_cfg_data[7:0];
                REG_LOOPS_PER_SET:  r_cfg.loops_per_set    <= i_cfg_data[7:0];
                REG_TRIG_LENGTH:    r_cfg.pulse_ticks      <= i_cfg_data[7:0];
                REG_BIT_ROUTE:      r_cfg.bit_route        <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/tss_step_map.sv
`timescale 1ns / 1ps
// Step decode: picks each channel's pattern bit for a step, applies the mute
// mask and routes the channel to its mapped output bit. Depends on tss_pkg.
module tss_step_map import tss_pkg::*; #(
    parameter int CHANNELS = 6
) (
    input  t_cfg       i_cfg,
    input  logic [3:0] i_step,
    output logic [7:0] o_bits
);

    logic [127:0] words;
    logic [7:0]   mutes;
    logic [3:0]   bit_sel;

    // Channels 6 and 7 have no pattern word and read as zero
    assign words   = {32'd0, i_cfg.pattern_second, i_cfg.pattern_first};
    assign mutes   = {2'b00, i_cfg.mute_mask};
    assign bit_sel = TOP_BIT - i_step;

    always_comb begin
        o_bits = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (!mutes[ch] && words[16*ch + int'(bit_sel)])
                o_bits[i_cfg.bit_route[3*ch +: 3]] = 1'b1;
        end
    end

endmodule

// File: design/trigger_step_sequencer.sv
`timescale 1ns / 1ps
// Trigger step sequencer top level. A request accepted into the input register
// moves on to the result register when that register is free (input register,
// then result register). Throughput: one request per cycle while the result
// output is not stalled; the step, bar and loop counters update with the result.
// Reset (i_rst_n low, synchronous) clears the handshake state, the counters and
// the configuration registers to their defaults; the first request may follow.
module trigger_step_sequencer import tss_pkg::*; #(
    parameter int CHANNELS  = 6,
    parameter int MAX_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tss_req_if.sink               i_req_in,
    tss_res_if.source             o_res_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [4:0] MAX_LEN = 5'(MAX_STEPS);

    t_cfg cfg;

    // Input register
    logic r_in_valid, r_in_clk, r_in_rst;
    // Result register
    logic r_out_valid;
    t_res r_res;
    // Sequencer state
    logic       r_clk_before, r_rst_before;
    logic [3:0] r_up;
    logic [4:0] r_shown;
    logic [7:0] r_bar, r_loop, r_pulse, r_held;

    logic       out_free, fire, req_acc;
    logic [7:0] step_bits;
    logic       rst_edge, clk_edge;
    logic [3:0] play_step;
    logic [4:0] len, nxt;
    logic [3:0] n_up;
    logic [4:0] n_shown;
    logic [7:0] n_bar, n_loop, n_pulse, n_held;
    t_res       n_res;

    tss_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Edge detection; a reset edge sends the step back to 0 before a clock edge plays
    assign rst_edge  = r_in_rst && !r_rst_before;
    assign clk_edge  = r_in_clk && !r_clk_before;
    assign play_step = rst_edge ? 4'd0 : r_up;

    // Step decode runs on the step that a clock edge would play
    tss_step_map #(.CHANNELS(CHANNELS)) u_map (
        .i_cfg  (cfg),
        .i_step (play_step),
        .o_bits (step_bits)
    );

    // Handshake: input register drains whenever the result register frees
    assign out_free          = !r_out_valid || o_res_out.ready;
    assign fire              = r_in_valid && out_free;
    assign i_req_in.ready    = !r_in_valid || out_free;
    assign req_acc           = i_req_in.valid && i_req_in.ready;
    assign o_res_out.valid   = r_out_valid;
    assign o_res_out.payload = r_res;

    // One tick of the sequencer
    always_comb begin
        if (cfg.steps_in_pattern == 5'd0)
            len = 5'd1;
        else if (cfg.steps_in_pattern > MAX_LEN)
            len = MAX_LEN;
        else
            len = cfg.steps_in_pattern;

        // reset edge takes effect before a clock edge in the same tick
        n_up    = play_step;
        n_bar   = rst_edge ? 8'd0 : r_bar;
        n_loop  = rst_edge ? 8'd0 : r_loop;
        n_shown = rst_edge ? IDLE_STEP : r_shown;
        n_held  = r_held;
        n_pulse = r_pulse;
        nxt     = {1'b0, play_step} + 5'd1;

        n_res.bar_end = 1'b0;
        n_res.set_end = 1'b0;

        if (clk_edge) begin
            n_shown = {1'b0, play_step};
            n_held  = step_bits;
            n_pulse = cfg.pulse_ticks;
            if (nxt >= len) begin
                nxt           = 5'd0;
                n_res.bar_end = 1'b1;
                n_bar         = n_bar + 8'd1;
                if (n_bar >= cfg.bars_per_loop) begin
                    n_loop = n_loop + 8'd1;
                    n_bar  = 8'd0;
                end
                if (n_loop >= cfg.loops_per_set) begin
                    n_loop        = 8'd0;
                    n_res.set_end = 1'b1;
                end
            end
            n_up = nxt[3:0];
        end

        n_res.trigger_bits = (n_pulse != 8'd0) ? n_held : 8'd0;
        n_res.playing_step = n_shown;
        n_res.loop_index   = n_loop;
        if (n_pulse != 8'd0)
            n_pulse = n_pulse - 8'd1;
    end

    // Handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (req_acc)
                r_in_valid <= 1'b1;
            else if (fire)
                r_in_valid <= 1'b0;
            if (fire)
                r_out_valid <= 1'b1;
            else if (o_res_out.ready)
                r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_in_clk <= i_req_in.payload.clock_level;
            r_in_rst <= i_req_in.payload.reset_level;
        end
        if (fire)
            r_res <= n_res;
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_before <= 1'b0;
            r_rst_before <= 1'b0;
            r_up         <= 4'd0;
            r_shown      <= IDLE_STEP;
            r_bar        <= 8'd0;
            r_loop       <= 8'd0;
            r_pulse      <= 8'd0;
            r_held       <= 8'd0;
        end else if (fire) begin
            r_clk_before <= r_in_clk;
            r_rst_before <= r_in_rst;
            r_up         <= n_up;
            r_shown      <= n_shown;
            r_bar        <= n_bar;
            r_loop       <= n_loop;
            r_pulse      <= n_pulse;
            r_held       <= n_held;
        end
    end

`ifndef ASSERT_OFF
    // a set end only ever comes with a bar end
    a_set_needs_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.set_end |-> r_res.bar_end)
        else $error("set end without bar end");

    // upcoming step stays below the maximum pattern length
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_up < MAX_LEN)
        else $error("upcoming step out of range");

    // a lone reset edge leaves the sequencer idle
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_rst && !r_rst_before && !(r_in_clk && !r_clk_before)
        |=> r_shown == IDLE_STEP && r_up == 4'd0 && r_loop == 8'd0)
        else $error("reset edge did not clear the counters");

    // a clock edge always plays a real step
    a_clock_plays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_clk && !r_clk_before |=> r_shown != IDLE_STEP)
        else $error("clock edge left the sequencer idle");
`endif

endmodule
